// ----- sv/dqs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dqs_pkg
// Shared operation codes, status codes and the completion struct of the
// double ended queue with search.
// ----------------------------------------------------------------------------
package dqs_pkg;

   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;

   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic                vld;
      logic [STATUS_W-1:0] status;
      logic                found;
   } done_type;

endpackage
`default_nettype wire

// ----- sv/dqs_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dqs_store
// Entry memory of the ring: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
module dqs_store #(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 32,
   parameter int IDX_W       = 4
) (
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [IDX_W-1:0]       wr_addr,
   input  wire logic [VALUE_WIDTH-1:0] wr_data,
   input  wire logic [IDX_W-1:0]       rd_addr,
   output logic      [VALUE_WIDTH-1:0] rd_data
);

   logic [VALUE_WIDTH-1:0] mem [DEPTH];
   logic [VALUE_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- sv/dqs_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dqs_ctrl
// Sequencer of the queue: keeps head and count, applies pushes and pops,
// and steps the ring read pointer and the comparator through the entries on
// a search.
// ----------------------------------------------------------------------------
module dqs_ctrl
   import dqs_pkg::*;
#(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 32,
   parameter int IDX_W       = 4,
   parameter int CNT_W       = 5
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic [OP_W-1:0]        req_operation,
   input  wire logic signed [31:0]     req_value,
   input  wire logic                   hold,
   output logic                        ready,
   output done_type                    done,
   output logic [CNT_W-1:0]            occupancy,
   output logic                        wr_en,
   output logic [IDX_W-1:0]            wr_addr,
   output logic [VALUE_WIDTH-1:0]      wr_data,
   output logic [IDX_W-1:0]            rd_addr,
   input  wire logic [VALUE_WIDTH-1:0] rd_data
);

   localparam logic [0:0] S_IDLE = 1'b0;
   localparam logic [0:0] S_SCAN = 1'b1;
   localparam int SUM_W = CNT_W + 1;

   logic [0:0]             state_ff, state_in;
   logic [IDX_W-1:0]       head_ff, head_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]       ptr_ff, ptr_in;
   logic [CNT_W-1:0]       issued_ff, issued_in;
   logic                   cmp_vld_ff, cmp_vld_in;
   logic [VALUE_WIDTH-1:0] key_ff, key_in;

   logic [63:0]            wide_value;
   logic [VALUE_WIDTH-1:0] key;
   logic                   accept;
   logic                   full;
   logic                   empty;
   logic [IDX_W-1:0]       head_dec;
   logic [IDX_W-1:0]       head_inc;
   logic [IDX_W-1:0]       ptr_inc;
   logic [SUM_W-1:0]       tail_sum;
   logic [IDX_W-1:0]       tail;
   logic                   match;

   // sign-extend, then keep the low bits of the stored width
   assign wide_value = {{32{req_value[31]}}, req_value};
   assign key        = wide_value[VALUE_WIDTH-1:0];

   assign ready  = (state_ff == S_IDLE) && !hold;
   assign accept = req_valid && ready;
   assign full   = (count_ff == CNT_W'(DEPTH));
   assign empty  = (count_ff == '0);

   assign head_dec = (head_ff == '0) ? IDX_W'(DEPTH - 1) : head_ff - IDX_W'(1);
   assign head_inc = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);
   assign ptr_inc  = (ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : ptr_ff + IDX_W'(1);

   // head plus count stays below twice the depth
   assign tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail     = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                 : IDX_W'(tail_sum);

   assign match     = (rd_data == key_ff);
   assign rd_addr   = ptr_ff;
   assign wr_data   = key;
   assign occupancy = count_ff;

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      ptr_in     = ptr_ff;
      issued_in  = issued_ff;
      cmp_vld_in = 1'b0;
      key_in     = key_ff;
      wr_en      = 1'b0;
      wr_addr    = head_dec;
      done       = '{vld: 1'b0, status: ST_OK, found: 1'b0};
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               key_in   = key;
               done.vld = 1'b1;
               unique case (req_operation)
                  OP_PUSH_FRONT: begin
                     if (full) begin
                        done.status = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = head_dec;
                        head_in  = head_dec;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_PUSH_BACK: begin
                     if (full) begin
                        done.status = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = tail;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_POP_FRONT: begin
                     if (empty) begin
                        done.status = ST_EMPTY;
                     end else begin
                        head_in  = head_inc;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  OP_POP_BACK: begin
                     if (empty) begin
                        done.status = ST_EMPTY;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  OP_SEARCH: begin
                     if (!empty) begin
                        done.vld  = 1'b0;
                        state_in  = S_SCAN;
                        ptr_in    = head_ff;
                        issued_in = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            // read of the next entry overlaps the compare of the previous one
            if (issued_ff != count_ff) begin
               ptr_in     = ptr_inc;
               issued_in  = issued_ff + CNT_W'(1);
               cmp_vld_in = 1'b1;
            end
            if (cmp_vld_ff && (match || (issued_ff == count_ff))) begin
               done.vld   = 1'b1;
               done.found = match;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         head_ff    <= '0;
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      issued_ff <= issued_in;
      key_ff    <= key_in;
   end

endmodule
`default_nettype wire

// ----- sv/double_ended_queue_with_search_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue_with_search_top
// Ring-buffer deque of signed values with push and pop at both ends and a
// linear search over the stored entries.
// ----------------------------------------------------------------------------
// Usage:
//   A request carries an operation (push front, push back, pop front,
//   pop back, search) and a value. Each request gives exactly one response
//   with status (ok, full, empty), a found flag and the occupancy after it.
//   req_stall is high from the cycle after a request is taken until its
//   response has been taken, so one request is in flight at a time.
//   Pushes, pops, unknown codes and a search of an empty store: the
//   response is valid in the cycle after the request is taken.
//   Search over stored entries: the single read port of the entry memory
//   feeds one comparator, one entry per cycle; the search stops at the
//   first hit, else after the last stored entry.
//   When rsp_stall is high the response holds and no new request is taken.
//   Reset empties the queue and drops any pending response; the entry
//   memory itself is not cleared, no clearing pass is needed.
// ----------------------------------------------------------------------------
module double_ended_queue_with_search_top
   import dqs_pkg::*;
#(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [OP_W-1:0]               req_operation,
   input  wire logic signed [31:0]            req_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [STATUS_W-1:0]                rsp_status,
   output logic                               rsp_found,
   output logic [$clog2(DEPTH + 1)-1:0]       rsp_occupancy
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic                   rsp_valid_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic                   rsp_found_ff;
   logic                   ready;
   done_type               done;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [VALUE_WIDTH-1:0] wr_data;
   logic [IDX_W-1:0]       rd_addr;
   logic [VALUE_WIDTH-1:0] rd_data;

   dqs_ctrl #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_value     (req_value),
      .hold          (rsp_valid_ff),
      .ready         (ready),
      .done          (done),
      .occupancy     (rsp_occupancy),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data)
   );

   dqs_store #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH),
      .IDX_W       (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // response register; occupancy comes straight from the count register,
   // which cannot move while a response is pending
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done.vld) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done.vld) begin
         rsp_status_ff <= done.status;
         rsp_found_ff  <= done.found;
      end
   end

   assign req_stall  = !ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_found  = rsp_found_ff;

endmodule
`default_nettype wire

// ----- sv/dqs_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dqs_checker
// Port-level checks of the deque: response hold, one request in flight,
// and consistency of status with occupancy.
// ----------------------------------------------------------------------------
module dqs_checker
   import dqs_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_stall,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic [STATUS_W-1:0]          rsp_status,
   input wire logic                         rsp_found,
   input wire logic [$clog2(DEPTH + 1)-1:0] rsp_occupancy
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_found) && $stable(rsp_occupancy))
      else $error("response changed while stalled");

   // a taken request must be followed by req_stall high
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while one is in flight");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |->
         (rsp_occupancy == CNT_W'(DEPTH)) && !rsp_found)
      else $error("full status without a full store");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY) |-> (rsp_occupancy == '0) && !rsp_found)
      else $error("empty status without an empty store");

   a_found_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> (rsp_occupancy != '0) && (rsp_status == ST_OK))
      else $error("search hit on an empty store");

endmodule

bind double_ended_queue_with_search_top dqs_checker #(
   .DEPTH (DEPTH)
) u_dqs_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_status    (rsp_status),
   .rsp_found     (rsp_found),
   .rsp_occupancy (rsp_occupancy)
);
`default_nettype wire

// ----- sim/tb_double_ended_queue_with_search_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue_with_search_top
// Self-checking bench for the ring-buffer deque with search. A shadow deque
// in the bench predicts status, found flag and occupancy for every accepted
// request. Directed cases cover empty, full, extreme values and unknown
// operations. Random sequences of random content fill, drain and search
// the store, first with both sides idling in random bursts, then back to back.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_with_search_top;
   import dqs_pkg::*;

   localparam int DEPTH       = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int OCC_W       = $clog2(DEPTH + 1);
   localparam int HALF_PERIOD = 6;

   localparam int OP_UNUSED_FIRST = 5;
   localparam int OP_UNUSED_LAST  = 7;

   localparam logic [31:0] VALUE_MIN = 32'h8000_0000;
   localparam logic [31:0] VALUE_MAX = 32'h7fff_ffff;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                found;
      logic [OCC_W-1:0]    occupancy;
   } deque_response_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [OP_W-1:0]         req_operation = '0;
   logic signed [31:0]      req_value = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [STATUS_W-1:0]     rsp_status;
   logic                    rsp_found;
   logic [OCC_W-1:0]        rsp_occupancy;

   // shadow copy of the deque
   logic [31:0]             shadow_entries [DEPTH];
   int                      shadow_head = 0;
   int                      shadow_count = 0;

   deque_response_type      pending_responses [$];
   int                      mismatch_count = 0;
   bit                      quiet = 1'b0;
   int                      stall_left = 0;

   double_ended_queue_with_search_top #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_found     (rsp_found),
      .rsp_occupancy (rsp_occupancy)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // update the shadow deque and queue up the response it implies
   function automatic void shadow_apply(logic [OP_W-1:0] op, logic [31:0] value);
      deque_response_type r;
      r.status = ST_OK;
      r.found  = 1'b0;
      case (op)
         OP_PUSH_FRONT: begin
            if (shadow_count == DEPTH) begin
               r.status = ST_FULL;
            end else begin
               shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
               shadow_entries[shadow_head] = value;
               shadow_count++;
            end
         end
         OP_PUSH_BACK: begin
            if (shadow_count == DEPTH) begin
               r.status = ST_FULL;
            end else begin
               shadow_entries[(shadow_head + shadow_count) % DEPTH] = value;
               shadow_count++;
            end
         end
         OP_POP_FRONT: begin
            if (shadow_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               shadow_head = (shadow_head + 1) % DEPTH;
               shadow_count--;
            end
         end
         OP_POP_BACK: begin
            if (shadow_count == 0)
               r.status = ST_EMPTY;
            else
               shadow_count--;
         end
         OP_SEARCH: begin
            for (int i = 0; i < shadow_count; i++)
               if (shadow_entries[(shadow_head + i) % DEPTH] == value)
                  r.found = 1'b1;
         end
         default: ;
      endcase
      r.occupancy = OCC_W'(shadow_count);
      pending_responses.push_back(r);
   endfunction

   function automatic logic [31:0] random_value();
      case ($urandom_range(0, 7))
         0: return VALUE_MIN;
         1: return VALUE_MAX;
         2: return 32'h0;
         3: return 32'hffff_ffff;
         4: return 32'($urandom_range(0, 15));
         default: return $urandom;
      endcase
   endfunction

   // half the time hit a stored entry at any ring position, else a random value
   function automatic logic [31:0] search_value();
      if (shadow_count > 0 && $urandom_range(0, 1) == 0)
         return shadow_entries[(shadow_head + $urandom_range(0, shadow_count - 1)) % DEPTH];
      return random_value();
   endfunction

   task automatic send_request(input logic [OP_W-1:0] op, input logic [31:0] value);
      int gap;
      req_valid     <= 1'b1;
      req_operation <= op;
      req_value     <= value;
      do @(posedge clock); while (req_stall);
      shadow_apply(op, value);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 14);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random(input int push_weight, input int pop_weight);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < push_weight)
         send_request($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, random_value());
      else if (roll < push_weight + pop_weight)
         send_request($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, $urandom);
      else if (roll < 97)
         send_request(OP_SEARCH, search_value());
      else
         send_request(OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)), $urandom);
   endtask

   task automatic test_empty_store();
      send_request(OP_POP_FRONT, 32'h0);
      send_request(OP_POP_BACK, 32'hffff_ffff);
      send_request(OP_SEARCH, 32'h0);
   endtask

   task automatic test_unknown_operations();
      for (int code = OP_UNUSED_FIRST; code <= OP_UNUSED_LAST; code++)
         send_request(OP_W'(code), $urandom);
   endtask

   task automatic test_extreme_values();
      send_request(OP_PUSH_FRONT, VALUE_MIN);
      send_request(OP_PUSH_BACK, VALUE_MAX);
      send_request(OP_PUSH_FRONT, 32'h0);
      send_request(OP_PUSH_BACK, 32'hffff_ffff);
      send_request(OP_SEARCH, VALUE_MIN);
      send_request(OP_SEARCH, VALUE_MAX);
      send_request(OP_SEARCH, 32'h0);
      send_request(OP_SEARCH, 32'hffff_ffff);
      send_request(OP_SEARCH, 32'h1);
      send_request(OP_POP_BACK, 32'h0);
      send_request(OP_POP_FRONT, 32'h0);
      send_request(OP_POP_FRONT, 32'h0);
      // removes the last entry
      send_request(OP_POP_BACK, 32'h0);
      send_request(OP_POP_FRONT, 32'h0);
      send_request(OP_SEARCH, VALUE_MIN);
   endtask

   task automatic test_full_store();
      repeat (3) begin
         while (shadow_count < DEPTH)
            send_request($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK,
                         random_value());
         send_request(OP_PUSH_FRONT, random_value());
         send_request(OP_PUSH_BACK, random_value());
         send_request(OP_SEARCH, shadow_entries[(shadow_head + DEPTH - 1) % DEPTH]);
         send_request(OP_SEARCH, shadow_entries[shadow_head]);
         send_request(OP_SEARCH, search_value());
         while (shadow_count > 0) begin
            if ($urandom_range(0, 3) == 0)
               send_request(OP_SEARCH, search_value());
            send_request($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, $urandom);
         end
         send_request($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, $urandom);
      end
   endtask

   task automatic test_random_mix();
      for (int block = 0; block < 7; block++) begin
         repeat (50) begin
            case (block % 3)
               0: send_random(60, 20);
               1: send_random(20, 60);
               default: send_random(35, 35);
            endcase
         end
      end
   endtask

   task automatic test_back_to_back();
      quiet = 1'b1;
      repeat (80) send_random(35, 35);
   endtask

   // response side idles in random bursts unless quiet
   always @(posedge clock) begin
      if (quiet)
         stall_left = 0;
      else if (stall_left > 0)
         stall_left = stall_left - 1;
      else if ($urandom_range(0, 5) == 0)
         stall_left = $urandom_range(1, 14);
      rsp_stall <= (stall_left > 0);
   end

   always @(posedge clock) begin
      deque_response_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_responses.size() == 0) begin
            $error("response with no request outstanding: status %0d found %0d occupancy %0d",
                   rsp_status, rsp_found, rsp_occupancy);
            mismatch_count++;
         end else begin
            want = pending_responses.pop_front();
            if (rsp_status !== want.status) begin
               $error("status mismatch: expected %0d, got %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_found !== want.found) begin
               $error("found mismatch: expected %0d, got %0d", want.found, rsp_found);
               mismatch_count++;
            end
            if (rsp_occupancy !== want.occupancy) begin
               $error("occupancy mismatch: expected %0d, got %0d",
                      want.occupancy, rsp_occupancy);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_store();
      test_unknown_operations();
      test_extreme_values();
      test_full_store();
      test_random_mix();
      test_back_to_back();
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (DEPTH + 4) @(posedge clock);
      if (mismatch_count == 0 && pending_responses.size() == 0)
         $display("double_ended_queue_with_search_top test passed");
      else
         $display("double_ended_queue_with_search_top test failed");
      $finish;
   end

   initial begin
      #(2 * HALF_PERIOD * 400_000);
      $display("double_ended_queue_with_search_top test failed");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/dqs_pkg.sv
sv/dqs_store.sv
sv/dqs_ctrl.sv
sv/double_ended_queue_with_search_top.sv
sv/dqs_checker.sv
sim/tb_double_ended_queue_with_search_top.sv
